@@ hdl/ste_pkg.sv @@
// shared types, constants and helpers for the sinusoidal time embedding
package ste_pkg;

    localparam int IdxW     = 6;
    localparam int TimeW    = 24;
    localparam int RegW     = 32;
    localparam int OutW     = 16;
    localparam int CfgAddrW = 2;
    localparam int TabLen   = 24;
    localparam int XyW      = 34;
    localparam int ZW       = 33;

    localparam logic [CfgAddrW-1:0] RegTimeScale = 2'd0;
    localparam logic [CfgAddrW-1:0] RegFreqRatio = 2'd1;

    localparam logic [RegW-1:0] TimeScaleRst = 32'd65536;
    localparam logic [RegW-1:0] FreqRatioRst = 32'd3220753000;
    localparam logic [29:0]     InvTwoPi     = 30'd683565276;
    localparam logic signed [XyW-1:0] CordicGain = 34'sd652032874;

    typedef struct packed {
        logic [IdxW-1:0] idx;
        logic            last;
        logic [RegW-1:0] turns;
    } t_item;

    function automatic logic [RegW-1:0] atan_turn(input int k);
        logic [RegW-1:0] v;
        case (k)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41721;
            15: v = 32'd20860;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2607;
            19: v = 32'd1303;
            20: v = 32'd651;
            21: v = 32'd325;
            22: v = 32'd162;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // round to q1.15 and saturate
    function automatic logic [OutW-1:0] to_q15(input logic signed [XyW-1:0] a);
        logic signed [XyW:0] s;
        logic signed [XyW:0] r;
        logic [OutW-1:0]     q;
        s = (XyW+1)'(a) + (XyW+1)'(16384);
        r = s >>> 15;
        if (r > (XyW+1)'(32767)) begin
            q = 16'h7fff;
        end else if (r < -(XyW+1)'(32768)) begin
            q = 16'h8000;
        end else begin
            q = r[OutW-1:0];
        end
        return q;
    endfunction

endpackage

@@ hdl/ste_front.sv @@
// front end: frequency sequencer and phase-to-turns multipliers
module ste_front #(
    parameter int HALF = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [23:0]        i_time,
    input  logic [31:0]               i_time_scale,
    input  logic [31:0]               i_freq_ratio,
    input  logic                      i_q_full,
    output logic                      o_q_push,
    output ste_pkg::t_item            o_q_item
);
    import ste_pkg::*;

    logic                    r_busy;
    logic [IdxW-1:0]         r_idx;
    logic signed [TimeW-1:0] r_t;
    logic [RegW-1:0]         r_f;

    logic                    r_a_v;
    logic [IdxW-1:0]         r_a_idx;
    logic                    r_a_last;
    logic [63:0]             r_a_p;

    logic                    r_b_v;
    logic [IdxW-1:0]         r_b_idx;
    logic                    r_b_last;
    logic [61:0]             r_b_lo;
    logic [RegW-1:0]         r_b_hi;

    logic                    en;
    logic                    seq_last;
    logic                    acc;
    logic [63:0]             n_f_prod;
    logic signed [56:0]      p_full;
    logic [61:0]             m_hi;

    assign en       = !(r_b_v && i_q_full);
    assign seq_last = r_idx == IdxW'(HALF - 1);
    assign o_ready  = en && (!r_busy || seq_last);
    assign acc      = i_valid && o_ready;
    assign n_f_prod = 64'(r_f) * 64'(i_freq_ratio);
    assign p_full   = r_t * $signed({1'b0, r_f});
    assign m_hi     = r_a_p[63:32] * InvTwoPi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_a_v  <= 1'b0;
            r_b_v  <= 1'b0;
        end else if (en) begin
            if (acc) begin
                r_busy <= 1'b1;
            end else if (seq_last) begin
                r_busy <= 1'b0;
            end
            r_a_v <= r_busy;
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (acc) begin
                r_t   <= i_time;
                r_f   <= i_time_scale;
                r_idx <= '0;
            end else if (r_busy) begin
                r_f   <= n_f_prod[63:32];
                r_idx <= r_idx + IdxW'(1);
            end
            r_a_idx  <= r_idx;
            r_a_last <= seq_last;
            r_a_p    <= 64'(p_full);
            r_b_idx  <= r_a_idx;
            r_b_last <= r_a_last;
            r_b_lo   <= r_a_p[31:0] * InvTwoPi;
            r_b_hi   <= m_hi[31:0];
        end
    end

    assign o_q_push       = r_b_v && !i_q_full;
    assign o_q_item.idx   = r_b_idx;
    assign o_q_item.last  = r_b_last;
    assign o_q_item.turns = {2'b00, r_b_lo[61:32]} + r_b_hi;

endmodule

@@ hdl/ste_queue.sv @@
// small item queue between front and back
module ste_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ste_pkg::t_item i_item,
    input  logic           i_pop,
    output ste_pkg::t_item o_item,
    output logic           o_full,
    output logic           o_empty
);
    import ste_pkg::*;

    t_item      r_mem [0:3];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;

    assign o_full  = r_cnt == 3'd4;
    assign o_empty = r_cnt == 3'd0;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

@@ hdl/ste_back.sv @@
// back end: quadrant fold, pipelined cordic, rounding and output register
module ste_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  ste_pkg::t_item i_q_item,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [5:0]     o_idx,
    output logic [15:0]    o_sin,
    output logic [15:0]    o_cos,
    output logic           o_last
);
    import ste_pkg::*;

    localparam int N = (CORDIC_STEPS > TabLen) ? TabLen : CORDIC_STEPS;

    logic                  r_v    [0:N];
    logic                  r_flip [0:N];
    logic                  r_lst  [0:N];
    logic [IdxW-1:0]       r_id   [0:N];
    logic signed [XyW-1:0] r_x    [0:N];
    logic signed [XyW-1:0] r_y    [0:N];
    logic signed [ZW-1:0]  r_z    [0:N];

    logic                  r_ov;
    logic [IdxW-1:0]       r_oidx;
    logic [OutW-1:0]       r_osin;
    logic [OutW-1:0]       r_ocos;
    logic                  r_olast;

    logic                  en;
    logic                  flip0;
    logic [RegW-1:0]       z0;
    logic signed [XyW-1:0] xf;
    logic signed [XyW-1:0] yf;

    assign en      = !r_ov || i_ready;
    assign o_q_pop = en && !i_q_empty;
    assign flip0   = i_q_item.turns[31] ^ i_q_item.turns[30];
    assign z0      = {i_q_item.turns[31] ^ flip0, i_q_item.turns[30:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_flip[0] <= flip0;
            r_lst[0]  <= i_q_item.last;
            r_id[0]   <= i_q_item.idx;
            r_x[0]    <= CordicGain;
            r_y[0]    <= '0;
            r_z[0]    <= ZW'($signed(z0));
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic signed [XyW-1:0] x_sh;
        logic signed [XyW-1:0] y_sh;
        logic signed [ZW-1:0]  ang;
        assign x_sh = r_x[k] >>> k;
        assign y_sh = r_y[k] >>> k;
        assign ang  = ZW'(atan_turn(k));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_flip[k+1] <= r_flip[k];
                r_lst[k+1]  <= r_lst[k];
                r_id[k+1]   <= r_id[k];
                if (!r_z[k][ZW-1]) begin
                    r_x[k+1] <= r_x[k] - y_sh;
                    r_y[k+1] <= r_y[k] + x_sh;
                    r_z[k+1] <= r_z[k] - ang;
                end else begin
                    r_x[k+1] <= r_x[k] + y_sh;
                    r_y[k+1] <= r_y[k] - x_sh;
                    r_z[k+1] <= r_z[k] + ang;
                end
            end
        end
    end

    assign xf = r_flip[N] ? -r_x[N] : r_x[N];
    assign yf = r_flip[N] ? -r_y[N] : r_y[N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_oidx  <= r_id[N];
            r_olast <= r_lst[N];
            r_osin  <= to_q15(yf);
            r_ocos  <= to_q15(xf);
        end
    end

    assign o_valid = r_ov;
    assign o_idx   = r_oidx;
    assign o_sin   = r_osin;
    assign o_cos   = r_ocos;
    assign o_last  = r_olast;

endmodule

@@ hdl/sinusoidal_time_embedding.sv @@
// top level of the sinusoidal time embedding
// usage:
//   s_axis carries one signed q8.16 time sample per item in tdata[23:0]
//   m_axis returns EMBED_DIM/2 items per sample, one per frequency index,
//   with sin and cos in q1.15 and tlast on the final index
//   registers are written through i_cfg_wr_en/i_cfg_addr/i_cfg_wr_data, index 0 time_scale
//   (q16.16), index 1 freq_ratio (q0.32); the user must write them only while idle, unchecked
// throughput: one result item per cycle while m_axis_tready is high; the
//   frequency sequencer issues one index per cycle while the queue is not
//   full and takes the next sample in the same cycle as the last index
// the path from sample to first result runs through the phase multiplier
//   stages, the queue and one cordic stage per step
// reset clears all valid flags and loads the register defaults
// a stalled receiver holds the output register and the cordic pipeline; the
//   front keeps filling the four-entry queue and then stalls s_axis
module sinusoidal_time_embedding #(
    parameter int EMBED_DIM    = 64,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,  // time_value
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [39:0]                    m_axis_tdata,  // freq_index, sine_value, cosine_value
    output logic                           m_axis_tlast,
    input  logic                           i_cfg_wr_en,
    input  logic [ste_pkg::CfgAddrW-1:0]   i_cfg_addr,
    input  logic [31:0]                    i_cfg_wr_data
);
    import ste_pkg::*;

    localparam int HALF = EMBED_DIM / 2;

    logic [RegW-1:0] r_time_scale;
    logic [RegW-1:0] r_freq_ratio;

    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    t_item           q_in;
    t_item           q_out;

    logic [IdxW-1:0] o_idx;
    logic [OutW-1:0] o_sin;
    logic [OutW-1:0] o_cos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_scale <= TimeScaleRst;
            r_freq_ratio <= FreqRatioRst;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                RegTimeScale: r_time_scale <= i_cfg_wr_data;
                RegFreqRatio: r_freq_ratio <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    ste_front #(.HALF(HALF)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_time       ($signed(s_axis_tdata)),
        .i_time_scale (r_time_scale),
        .i_freq_ratio (r_freq_ratio),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_item     (q_in)
    );

    ste_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ste_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_item  (q_out),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_idx     (o_idx),
        .o_sin     (o_sin),
        .o_cos     (o_cos),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, o_cos, o_sin, o_idx};

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (o_idx == IdxW'(HALF - 1)))
        else $error("tlast on wrong index");

    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

@@ verif/sinusoidal_time_embedding_test.sv @@
// testbench for the sinusoidal time embedding: random and directed time samples, checked per item
module sinusoidal_time_embedding_test;
    import ste_pkg::*;

    localparam int EmbedDim    = 64;
    localparam int CordicSteps = 16;
    localparam int HalfDim     = EmbedDim / 2;
    localparam int CycleLimit  = 1000000;

    typedef struct {
        logic [5:0]  idx;
        logic [15:0] sin_q15;
        logic [15:0] cos_q15;
        logic        last;
    } t_embed;

    class embed_scoreboard;
        logic [31:0] time_scale;
        logic [31:0] freq_ratio;
        t_embed      pending[$];
        int          errors;

        function void load_defaults();
            time_scale = 32'd65536;
            freq_ratio = 32'd3220753000;
        endfunction

        function void write_reg(logic [CfgAddrW-1:0] addr, logic [31:0] val);
            if (addr == RegTimeScale) time_scale = val;
            else if (addr == RegFreqRatio) freq_ratio = val;
        endfunction

        function logic [15:0] round_q15(longint v);
            longint r;
            r = (v + 64'sd16384) >>> 15;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r[15:0];
        endfunction

        function void rotate(logic [31:0] turns, output logic [15:0] s, output logic [15:0] c);
            longint atan_tab[24] = '{536870912, 316933406, 167458907, 85004756,
                42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                333772, 166886, 83443, 41721, 20860, 10430, 5215, 2607, 1303,
                651, 325, 162, 81};
            longint z, x, y, nx;
            bit     flip;
            int     n;
            z = longint'({32'd0, turns});
            x = 64'sd652032874;
            y = 0;
            flip = 0;
            if (z >= 64'sd2147483648) z -= 64'sd4294967296;
            if (z >= 64'sd1073741824) begin
                z -= 64'sd2147483648;
                flip = 1;
            end else if (z < -64'sd1073741824) begin
                z += 64'sd2147483648;
                flip = 1;
            end
            n = (CordicSteps > 24) ? 24 : CordicSteps;
            for (int k = 0; k < n; k++) begin
                if (z >= 0) begin
                    nx = x - (y >>> k);
                    y = y + (x >>> k);
                    z -= atan_tab[k];
                end else begin
                    nx = x + (y >>> k);
                    y = y - (x >>> k);
                    z += atan_tab[k];
                end
                x = nx;
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            s = round_q15(y);
            c = round_q15(x);
        endfunction

        function void note_sample(logic [23:0] tv);
            longint          t;
            longint unsigned f, p, w;
            t_embed          e;
            int              cnt;
            t = longint'(signed'(tv));
            f = {32'd0, time_scale};
            cnt = (HalfDim > 64) ? 64 : HalfDim;
            for (int i = 0; i < cnt; i++) begin
                p = longint'(t) * f;
                w = p * 64'd683565276;
                e.idx = i[5:0];
                rotate(w[63:32], e.sin_q15, e.cos_q15);
                e.last = (i == cnt - 1);
                pending.push_back(e);
                f = (f * {32'd0, freq_ratio}) >> 32;
            end
        endfunction

        function void check_item(logic [39:0] data, logic last);
            t_embed e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected item %h last %b", data, last);
                return;
            end
            e = pending.pop_front();
            if (data[5:0] !== e.idx || data[21:6] !== e.sin_q15 ||
                data[37:22] !== e.cos_q15 || data[39:38] !== 2'b00 || last !== e.last) begin
                errors++;
                if (errors <= 10)
                    $display("item mismatch: exp idx %0d sin %h cos %h last %b, got idx %0d sin %h cos %h last %b",
                             e.idx, e.sin_q15, e.cos_q15, e.last,
                             data[5:0], data[21:6], data[37:22], last);
            end
        endfunction
    endclass

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              s_axis_tvalid = 0;
    logic              s_axis_tready;
    logic [23:0]       s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 0;
    logic [39:0]       m_axis_tdata;  // freq_index, sine_value, cosine_value
    logic              m_axis_tlast;
    logic              i_cfg_wr_en = 0;
    logic [CfgAddrW-1:0] i_cfg_addr = '0;
    logic [31:0]       i_cfg_wr_data = '0;

    embed_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  recv_hold = 0;
    int  cycles = 0;

    sinusoidal_time_embedding #(.EMBED_DIM(EmbedDim), .CORDIC_STEPS(CordicSteps)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_addr(i_cfg_addr), .i_cfg_wr_data(i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_item(m_axis_tdata, m_axis_tlast);
        m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_sample(logic [23:0] tv);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= tv;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CfgAddrW-1:0] addr, logic [31:0] val);
        i_cfg_wr_en <= 1;
        i_cfg_addr <= addr;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        sb.write_reg(addr, val);
        i_cfg_wr_en <= 0;
        @(posedge i_clk);
    endtask

    task automatic send_random(int n);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(3))
                0: send_sample(24'($urandom_range(255)) - 24'd128);
                default: send_sample(24'($urandom));
            endcase
        end
    endtask

    initial begin
        logic [23:0] directed[] = '{24'h000000, 24'h7fffff, 24'h800000, 24'h000001,
            24'hffffff, 24'h010000, 24'hff0000, 24'h019220, 24'h03243f, 24'h5555aa,
            24'haaaa55, 24'h00c910};
        sb.load_defaults();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        foreach (directed[k]) send_sample(directed[k]);
        send_random(50);
        drain();

        // tiny first frequency, ratio near one
        cfg_write(RegTimeScale, 32'd1);
        cfg_write(RegFreqRatio, 32'hffffffff);
        send_idle_pct = 73;
        foreach (directed[k]) send_sample(directed[k]);
        send_random(50);
        drain();

        // huge frequency decaying to zero at once
        cfg_write(RegTimeScale, 32'hffffffff);
        cfg_write(RegFreqRatio, 32'd1);
        send_idle_pct = 0;
        recv_stall_pct = 73;
        send_random(60);
        drain();

        // zero registers, then writes to unused indexes
        cfg_write(RegTimeScale, 32'd0);
        cfg_write(RegFreqRatio, 32'd0);
        send_random(10);
        drain();
        cfg_write(2'd2, $urandom);
        cfg_write(2'd3, $urandom);
        send_random(10);
        drain();

        cfg_write(RegTimeScale, $urandom);
        cfg_write(RegFreqRatio, $urandom | 32'h80000000);
        send_idle_pct = 20;
        recv_stall_pct = 20;
        send_random(80);
        drain();

        // long receiver hold while the sender keeps offering
        cfg_write(RegTimeScale, 32'd65536);
        cfg_write(RegFreqRatio, 32'd3220753000);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                recv_hold = 1;
                repeat (600) @(posedge i_clk);
                recv_hold = 0;
            end
            send_random(20);
        join
        send_random(80);
        drain();

        if (sb.pending.size() != 0) sb.errors++;
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

@@ sim.f @@
hdl/ste_pkg.sv
hdl/ste_front.sv
hdl/ste_queue.sv
hdl/ste_back.sv
hdl/sinusoidal_time_embedding.sv
verif/sinusoidal_time_embedding_test.sv
